// ===== rtl/hct_pkg.sv =====
// package for the hydro cell temperature block: widths, payload structs,
// register indexes and reset values; no dependencies
`default_nettype none
package hct_pkg;
	localparam int VALUE_WIDTH = 48;
	localparam int DIMENSIONS = 3;
	localparam int REG_WIDTH = 47;
	localparam int FRAC_BITS = 24;
	localparam int IDX_WIDTH = 2;

	localparam logic [IDX_WIDTH-1:0] REG_SMALL_DENSITY = 2'd0;
	localparam logic [IDX_WIDTH-1:0] REG_ENERGY_FACTOR = 2'd1;
	localparam logic [IDX_WIDTH-1:0] REG_TEMP_SCALE = 2'd2;

	localparam logic [REG_WIDTH-1:0] RST_SMALL_DENSITY = 47'd1;
	localparam logic [REG_WIDTH-1:0] RST_ENERGY_FACTOR = 47'd23488102;
	localparam logic [REG_WIDTH-1:0] RST_TEMP_SCALE = 47'd16777216;

	typedef struct packed {
		logic signed [47:0] density_in;
		logic signed [47:0] momentum_x;
		logic signed [47:0] momentum_y;
		logic signed [47:0] momentum_z;
		logic signed [47:0] total_energy;
		logic signed [47:0] metal_density;
	} cell_t;

	typedef struct packed {
		logic [46:0] density_out;
		logic signed [47:0] temperature;
		logic signed [47:0] metallicity;
	} result_t;
endpackage
`default_nettype wire

// ===== rtl/hydro_cell_temperature.sv =====
// top level of the hydro cell temperature pipeline
// depends on hct_pkg, hct_mul, hct_div
//
// channel  handshake          payload
// cell     start / busy       cell_data (hct_pkg::cell_t)
// result   result_valid       result (hct_pkg::result_t)
// config   cfg_valid/ready    cfg_index, cfg_data
//
// fully pipelined: one cell per cycle, and busy is held low so nothing stalls
// the input; each cell passes through the two 48-stage dividers in series
// (kinetic and metal side by side, then P)
// busy is held low; results leave on their strobe for one cycle
// reset clears the valid bits and loads the register reset values
`default_nettype none
module hydro_cell_temperature #(
	parameter int DIMENSIONS = hct_pkg::DIMENSIONS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire hct_pkg::cell_t cell_data,
	output logic result_valid,
	output hct_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [hct_pkg::IDX_WIDTH-1:0] cfg_index,
	input wire logic [hct_pkg::REG_WIDTH-1:0] cfg_data
);
	localparam logic [47:0] VMAX = {1'b0, {47{1'b1}}};
	localparam logic [47:0] VNEG = {1'b1, 47'd0};
	localparam logic [47:0] ONE = 48'd1 << hct_pkg::FRAC_BITS;
	localparam logic [47:0] FIFTY = 48'd50 << hct_pkg::FRAC_BITS;

	logic [46:0] small_q, ef_q, ts_q;
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_q <= hct_pkg::RST_SMALL_DENSITY;
			ef_q <= hct_pkg::RST_ENERGY_FACTOR;
			ts_q <= hct_pkg::RST_TEMP_SCALE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hct_pkg::REG_SMALL_DENSITY: small_q <= cfg_data;
				hct_pkg::REG_ENERGY_FACTOR: ef_q <= cfg_data;
				hct_pkg::REG_TEMP_SCALE: ts_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: floor, magnitudes
	logic v_s1;
	logic [47:0] rho_s1, mm_s1, px_s1, py_s1, pz_s1;
	logic mneg_s1;
	logic signed [47:0] e_s1;
	logic [46:0] fl;
	always_comb fl = (small_q == '0) ? 47'd1 : small_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		rho_s1 <= (cell_data.density_in > $signed({1'b0, fl})) ?
			cell_data.density_in : {1'b0, fl};
		mneg_s1 <= cell_data.metal_density[47];
		mm_s1 <= cell_data.metal_density[47] ? -cell_data.metal_density :
			cell_data.metal_density;
		px_s1 <= cell_data.momentum_x[47] ? -cell_data.momentum_x : cell_data.momentum_x;
		py_s1 <= (DIMENSIONS < 2) ? '0 :
			(cell_data.momentum_y[47] ? -cell_data.momentum_y : cell_data.momentum_y);
		pz_s1 <= (DIMENSIONS < 3) ? '0 :
			(cell_data.momentum_z[47] ? -cell_data.momentum_z : cell_data.momentum_z);
		e_s1 <= cell_data.total_energy;
	end

	// squared momenta and metal times fifty
	localparam int TA = 48 + 48 + 1;
	logic [95:0] sqx, sqy, sqz, mz;
	logic [TA-1:0] ta_o;
	logic va;
	hct_mul #(.TW(TA)) u_mx (.clk, .arst_n, .in_valid(v_s1), .a(px_s1), .b(px_s1),
		.tag_in({rho_s1, e_s1, mneg_s1}), .out_valid(va), .prod(sqx),
		.tag_out(ta_o));
	hct_mul #(.TW(1)) u_my (.clk, .arst_n, .in_valid(v_s1), .a(py_s1), .b(py_s1),
		.tag_in(1'b0), .out_valid(), .prod(sqy), .tag_out());
	hct_mul #(.TW(1)) u_mz (.clk, .arst_n, .in_valid(v_s1), .a(pz_s1), .b(pz_s1),
		.tag_in(1'b0), .out_valid(), .prod(sqz), .tag_out());
	hct_mul #(.TW(1)) u_mm (.clk, .arst_n, .in_valid(v_s1), .a(mm_s1), .b(FIFTY),
		.tag_in(1'b0), .out_valid(), .prod(mz), .tag_out());

	// stage: sum squares
	logic v_s2, mneg_s2;
	logic [97:0] ss_s2;
	logic [95:0] mz_s2;
	logic [47:0] rho_s2;
	logic signed [47:0] e_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= va;
	end
	always_ff @(posedge clk) begin
		ss_s2 <= {2'b0, sqx} + {2'b0, sqy} + {2'b0, sqz};
		mz_s2 <= mz;
		rho_s2 <= ta_o[TA-1 -: 48];
		e_s2 <= ta_o[TA-49 -: 48];
		mneg_s2 <= ta_o[0];
	end

	// kinetic and metal quotients in parallel; dividing by 2*rho = shift sum
	localparam int TB = 48 + 48 + 1;
	logic [47:0] kq, zq;
	logic [TB-1:0] tb_o;
	logic vb;
	hct_div #(.NW(96), .DW(48), .QW(48), .TW(TB)) u_dk (.clk, .arst_n,
		.in_valid(v_s2), .num(ss_s2[96:1]), .den(rho_s2), .lim(VMAX),
		.tag_in({rho_s2, e_s2, mneg_s2}), .out_valid(vb), .quo(kq),
		.tag_out(tb_o));
	logic [47:0] rho_b;
	logic signed [47:0] e_b;
	logic mneg_b;
	assign rho_b = tb_o[TB-1 -: 48];
	assign e_b = tb_o[TB-49 -: 48];
	assign mneg_b = tb_o[0];
	// metal quotient in its own divider, built like the kinetic one so both quotients line up
	logic [47:0] zq_b;
	logic vz;
	hct_div #(.NW(96), .DW(48), .QW(48), .TW(1)) u_dz (.clk, .arst_n,
		.in_valid(v_s2), .num(mz_s2), .den(rho_s2),
		.lim(mneg_s2 ? VNEG : VMAX), .tag_in(1'b0), .out_valid(vz), .quo(zq_b),
		.tag_out());
	assign zq = zq_b;

	// internal energy with saturation
	logic v_s3, uneg_s3;
	logic [47:0] um_s3, rho_s3, z_s3;
	logic signed [48:0] ud;
	always_comb ud = {e_b[47], e_b} - {1'b0, kq};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= vb && vz;
	end
	always_ff @(posedge clk) begin
		rho_s3 <= rho_b;
		z_s3 <= (mneg_b && zq != '0) ? -zq : zq;
		if (ud < -$signed(49'sh800000000000)) begin
			uneg_s3 <= 1'b1;
			um_s3 <= VNEG;
		end else begin
			uneg_s3 <= ud[48];
			um_s3 <= ud[48] ? 48'(-ud) : ud[47:0];
		end
	end

	// G = ef * U / one: shift and saturate
	localparam int TC = 1 + 48 + 48;
	logic [95:0] gp;
	logic [TC-1:0] tc_o;
	logic vc;
	hct_mul #(.TW(TC)) u_mg (.clk, .arst_n, .in_valid(v_s3), .a(um_s3),
		.b({1'b0, ef_q}), .tag_in({uneg_s3, rho_s3, z_s3}), .out_valid(vc),
		.prod(gp), .tag_out(tc_o));
	logic v_s4, gneg_s4;
	logic [47:0] gm_s4, rho_s4, z_s4;
	logic [47:0] glim;
	always_comb glim = tc_o[TC-1] ? VNEG : VMAX;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= vc;
	end
	always_ff @(posedge clk) begin
		gneg_s4 <= tc_o[TC-1] && (gp[95:24] != '0);
		gm_s4 <= (gp[95:24] > {24'd0, glim}) ? glim : gp[71:24];
		rho_s4 <= tc_o[95:48];
		z_s4 <= tc_o[47:0];
	end

	// P = G * one / rho
	localparam int TD = 1 + 48;
	logic [47:0] pq;
	logic [TD-1:0] td_o;
	logic vd;
	hct_div #(.NW(96), .DW(48), .QW(48), .TW(TD)) u_dp (.clk, .arst_n,
		.in_valid(v_s4), .num({24'd0, gm_s4, 24'd0}), .den(rho_s4),
		.lim(gneg_s4 ? VNEG : VMAX), .tag_in({gneg_s4, z_s4}), .out_valid(vd),
		.quo(pq), .tag_out(td_o));

	// T = P * ts / one
	logic [95:0] tp;
	logic [TD-1:0] te_o;
	logic ve;
	hct_mul #(.TW(TD)) u_mt (.clk, .arst_n, .in_valid(vd), .a(pq),
		.b({1'b0, ts_q}), .tag_in({td_o[TD-1] && pq != '0, td_o[47:0]}),
		.out_valid(ve), .prod(tp), .tag_out(te_o));

	// density pipe delay line matched to the path above
	localparam int RD = 51;
	logic [47:0] rd_q [RD];
	always_ff @(posedge clk) begin
		rd_q[0] <= rho_s4;
		for (int i = 1; i < RD; i++) rd_q[i] <= rd_q[i-1];
	end

	// final saturation and output register
	logic [47:0] tlim, tmag;
	always_comb begin
		tlim = te_o[TD-1] ? VNEG : VMAX;
		tmag = (tp[95:24] > {24'd0, tlim}) ? tlim : tp[71:24];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= ve;
	end
	always_ff @(posedge clk) begin
		result.density_out <= rd_q[RD-1][46:0];
		result.temperature <= te_o[TD-1] ? -tmag : tmag;
		result.metallicity <= te_o[47:0];
	end
endmodule
`default_nettype wire

// ===== rtl/hct_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating
// quotient; no package dependencies
`default_nettype none
module hct_div #(
	parameter int NW = 96,
	parameter int DW = 48,
	parameter int QW = 48,
	parameter int TW = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [NW-1:0] num,
	input wire logic [DW-1:0] den,
	input wire logic [QW-1:0] lim,
	input wire logic [TW-1:0] tag_in,
	output logic out_valid,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	localparam int QB = NW - DW;
	// stage registers: remainder, remaining numerator bits, quotient
	logic [NW-1:0] sh_s [QB];
	logic [DW:0] r_s [QB];
	logic [QB-1:0] q_s [QB];
	logic [DW-1:0] d_s [QB];
	logic [QW-1:0] l_s [QB];
	logic [TW-1:0] t_s [QB];
	logic ov_s [QB];
	logic v_s [QB];

	genvar g;
	generate
		for (g = 0; g < QB; g++) begin : g_st
			logic [NW-1:0] sh_i;
			logic [DW:0] r_i;
			logic [QB-1:0] q_i;
			logic [DW-1:0] d_i;
			logic [QW-1:0] l_i;
			logic [TW-1:0] t_i;
			logic ov_i, v_i;
			logic [DW:0] tr;
			// stage input: ports for the first stage, previous stage otherwise
			if (g == 0) begin : g_src
				always_comb begin
					sh_i = num;
					r_i = {1'b0, num[NW-1 -: DW]};
					q_i = '0;
					d_i = den;
					l_i = lim;
					t_i = tag_in;
					ov_i = num[NW-1 -: DW] >= den;
					v_i = in_valid;
				end
			end else begin : g_src
				always_comb begin
					sh_i = sh_s[g-1];
					r_i = r_s[g-1];
					q_i = q_s[g-1];
					d_i = d_s[g-1];
					l_i = l_s[g-1];
					t_i = t_s[g-1];
					ov_i = ov_s[g-1];
					v_i = v_s[g-1];
				end
			end
			always_comb tr = {r_i[DW-1:0], sh_i[QB-1-g]};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[g] <= 1'b0;
				else v_s[g] <= v_i;
			end
			always_ff @(posedge clk) begin
				if (tr >= {1'b0, d_i}) begin
					r_s[g] <= tr - {1'b0, d_i};
					q_s[g] <= {q_i[QB-2:0], 1'b1};
				end else begin
					r_s[g] <= tr;
					q_s[g] <= {q_i[QB-2:0], 1'b0};
				end
				sh_s[g] <= sh_i;
				d_s[g] <= d_i;
				l_s[g] <= l_i;
				t_s[g] <= t_i;
				ov_s[g] <= ov_i;
			end
		end
	endgenerate

	// saturate to the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= v_s[QB-1];
	end
	always_ff @(posedge clk) begin
		tag_out <= t_s[QB-1];
		if (ov_s[QB-1] || ((QW + QB)'(q_s[QB-1]) > (QW + QB)'(l_s[QB-1])))
			quo <= l_s[QB-1];
		else
			quo <= QW'(q_s[QB-1]);
	end
endmodule
`default_nettype wire

// ===== rtl/hct_mul.sv =====
// two-stage 48x48 unsigned multiplier built from 24-bit partial products;
// no package dependencies
`default_nettype none
module hct_mul #(
	parameter int TW = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [47:0] a,
	input wire logic [47:0] b,
	input wire logic [TW-1:0] tag_in,
	output logic out_valid,
	output logic [95:0] prod,
	output logic [TW-1:0] tag_out
);
	logic [47:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic [TW-1:0] tag_s1;
	logic v_s1;

	// partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		p00_s1 <= a[23:0] * b[23:0];
		p01_s1 <= a[23:0] * b[47:24];
		p10_s1 <= a[47:24] * b[23:0];
		p11_s1 <= a[47:24] * b[47:24];
		tag_s1 <= tag_in;
		// combine
		prod <= {p11_s1, p00_s1} + {24'd0, p01_s1, 24'd0} + {24'd0, p10_s1, 24'd0};
		tag_out <= tag_s1;
	end
endmodule
`default_nettype wire

// ===== bench/hydro_cell_temperature_tb.sv =====
// testbench for hydro_cell_temperature: drives cells and register writes and
// checks every result word against an internal fixed-point predictor
// depends on hct_pkg and the hydro_cell_temperature rtl
`default_nettype none
module hydro_cell_temperature_tb;

	localparam logic [63:0] VMAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] VNEG = 64'h0000_8000_0000_0000;
	localparam int DRAIN = 400;

	// scoreboard: predicts each cell's result and checks the outputs in order
	class cell_scoreboard;
		logic [46:0] floor_reg, efac_reg, tscale_reg;
		hct_pkg::result_t pending[$];
		int errors;
		int checked;

		function void set_reg(logic [hct_pkg::IDX_WIDTH-1:0] idx, logic [46:0] val);
			case (idx)
				hct_pkg::REG_SMALL_DENSITY: floor_reg = val;
				hct_pkg::REG_ENERGY_FACTOR: efac_reg = val;
				hct_pkg::REG_TEMP_SCALE: tscale_reg = val;
				default: ;
			endcase
		endfunction

		// saturate a signed magnitude to the 48-bit range
		function logic signed [63:0] clamp(logic neg, logic [127:0] mag);
			if (neg) begin
				if (mag > VNEG) mag = VNEG;
				return -$signed({1'b0, mag[62:0]});
			end
			if (mag > VMAX) mag = VMAX;
			return $signed(mag[63:0]);
		endfunction

		// trunc(x * b / d) saturated
		function logic signed [63:0] scaled(logic signed [63:0] x, logic [63:0] b,
				logic [63:0] d);
			logic neg;
			logic [63:0] m;
			neg = x < 0;
			m = neg ? -x : x;
			return clamp(neg, ({64'd0, m} * {64'd0, b}) / {64'd0, d});
		endfunction

		function void note_cell(hct_pkg::cell_t c);
			logic [63:0] fl, rho;
			logic signed [63:0] dens, en, z, u, g, p, t;
			logic [127:0] sq;
			logic [63:0] m;
			logic signed [63:0] mom[3];
			hct_pkg::result_t r;
			fl = floor_reg == 0 ? 64'd1 : {17'd0, floor_reg};
			if (fl > VMAX) fl = VMAX;
			dens = 64'(c.density_in);
			en = 64'(c.total_energy);
			rho = (dens > $signed(fl)) ? dens : fl;
			z = scaled(64'(c.metal_density), 64'd50 << hct_pkg::FRAC_BITS, rho);
			mom[0] = 64'(c.momentum_x);
			mom[1] = 64'(c.momentum_y);
			mom[2] = 64'(c.momentum_z);
			sq = 0;
			for (int i = 0; i < hct_pkg::DIMENSIONS; i++) begin
				m = mom[i] < 0 ? -mom[i] : mom[i];
				sq += {64'd0, m} * {64'd0, m};
			end
			sq = sq / {63'd0, rho, 1'b0};
			if (sq > VMAX) sq = VMAX;
			u = en - $signed(sq[63:0]);
			if (u < -$signed(VNEG)) u = -$signed(VNEG);
			g = scaled(u, {17'd0, efac_reg}, 64'd1 << hct_pkg::FRAC_BITS);
			p = scaled(g, 64'd1 << hct_pkg::FRAC_BITS, rho);
			t = scaled(p, {17'd0, tscale_reg}, 64'd1 << hct_pkg::FRAC_BITS);
			r.density_out = rho[46:0];
			r.temperature = t[47:0];
			r.metallicity = z[47:0];
			pending.push_back(r);
		endfunction

		function void check_word(hct_pkg::result_t got);
			hct_pkg::result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t unexpected result word %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			if (got.density_out !== exp_r.density_out) begin
				$display("%0t density_out exp %h got %h", $time, exp_r.density_out,
					got.density_out);
				errors++;
			end
			if (got.temperature !== exp_r.temperature) begin
				$display("%0t temperature exp %h got %h", $time, exp_r.temperature,
					got.temperature);
				errors++;
			end
			if (got.metallicity !== exp_r.metallicity) begin
				$display("%0t metallicity exp %h got %h", $time, exp_r.metallicity,
					got.metallicity);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, cfg_valid;
	logic busy, result_valid, cfg_ready;
	hct_pkg::cell_t cell_data;
	hct_pkg::result_t result;
	logic [hct_pkg::IDX_WIDTH-1:0] cfg_index;
	logic [hct_pkg::REG_WIDTH-1:0] cfg_data;
	cell_scoreboard sb;
	bit steady;
	int cells_sent;

	hydro_cell_temperature uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cell_data(cell_data),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_word(result);
	end

	// write one register, waiting on ready, then drop valid and idle before returning
	task automatic write_reg(logic [hct_pkg::IDX_WIDTH-1:0] idx, logic [46:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// send one cell with optional random idle before it
	task automatic send_cell(hct_pkg::cell_t c);
		if (!steady) begin
			while ($urandom_range(99) < 35) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		cell_data <= c;
		do @(posedge clk); while (busy);
		sb.note_cell(c);
		cells_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [47:0] rnd48();
		logic [47:0] v;
		case ($urandom_range(5))
			0: v = 48'({$urandom, $urandom});
			1: v = 48'(int'($urandom_range(64'h7FF)) - 1024) <<< $urandom_range(30);
			2: v = {24'(($urandom_range(1) != 0) ? -1 : 0), 24'($urandom)};
			3: v = 48'($urandom_range(32'h7FFF_FFFF));
			4: v = {$urandom_range(1) ? 1'b1 : 1'b0, 47'(0)} | 48'($urandom_range(3));
			default: v = 48'($urandom) << 16;
		endcase
		return v;
	endfunction

	function automatic hct_pkg::cell_t rnd_cell();
		hct_pkg::cell_t c;
		c.density_in = $urandom_range(3) == 0 ? rnd48() : 48'({$urandom_range(255), $urandom});
		c.momentum_x = rnd48();
		c.momentum_y = rnd48();
		c.momentum_z = rnd48();
		c.total_energy = rnd48();
		c.metal_density = rnd48();
		return c;
	endfunction

	function automatic hct_pkg::cell_t mk(logic [47:0] d, logic [47:0] m, logic [47:0] e,
			logic [47:0] z);
		hct_pkg::cell_t c;
		c.density_in = d;
		c.momentum_x = m;
		c.momentum_y = m;
		c.momentum_z = m;
		c.total_energy = e;
		c.metal_density = z;
		return c;
	endfunction

	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [47:0] mn, mx;
		sb = new();
		sb.floor_reg = hct_pkg::RST_SMALL_DENSITY;
		sb.efac_reg = hct_pkg::RST_ENERGY_FACTOR;
		sb.tscale_reg = hct_pkg::RST_TEMP_SCALE;
		mn = 48'h8000_0000_0000;
		mx = 48'h7FFF_FFFF_FFFF;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cell_data = '0;
		steady = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, negative and zero density, saturation
		send_cell(mk(48'd1 << 24, 48'd0, 48'd1 << 24, 48'd1 << 20));
		send_cell(mk(mn, mn, mn, mn));
		send_cell(mk(mx, mx, mx, mx));
		send_cell(mk(48'd0, mx, mn, mx));
		send_cell(mk(48'd1, 48'd1, mx, mn));
		send_cell(mk(mx, mn, mx, mx));
		send_cell(mk(-48'd5, 48'd77, 48'd3 << 24, -48'd9));
		send_cell(mk(48'd1 << 24, mn, mn, 48'd0));
		drain();
		// zero floor acts as one; large floor; zero factors
		write_reg(hct_pkg::REG_SMALL_DENSITY, 47'd0);
		write_reg(hct_pkg::REG_ENERGY_FACTOR, 47'd0);
		write_reg(hct_pkg::REG_TEMP_SCALE, 47'h7FFF_FFFF_FFFF);
		send_cell(mk(48'd0, 48'd3, 48'd1 << 30, 48'd1 << 24));
		send_cell(mk(mx, 48'd0, mx, mn));
		drain();
		write_reg(hct_pkg::REG_SMALL_DENSITY, 47'h7FFF_FFFF_FFFF);
		write_reg(hct_pkg::REG_ENERGY_FACTOR, 47'h7FFF_FFFF_FFFF);
		write_reg(hct_pkg::REG_TEMP_SCALE, 47'd0);
		send_cell(mk(mx, mx, mn, mx));
		send_cell(mk(mn, 48'd0, mx, mn));
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(hct_pkg::REG_SMALL_DENSITY,
				ph == 5 ? 47'd1 : 47'($urandom_range(1 << 26)));
			write_reg(hct_pkg::REG_ENERGY_FACTOR, ph == 0 ? hct_pkg::RST_ENERGY_FACTOR :
				47'($urandom_range(1 << 27)));
			write_reg(hct_pkg::REG_TEMP_SCALE, ph == 4 ? 47'h7FFF_FFFF_FFFF :
				47'($urandom_range(1 << 30)));
			for (int i = 0; i < 90; i++) begin
				steady = (ph == 2);
				send_cell(rnd_cell());
			end
			drain();
		end
		steady = 0;
		$display("run covered %0d cells over reset, extreme and random register settings",
			cells_sent);
		$display("%0d result words checked, %0d errors", sb.checked, sb.errors);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
